// ----- src/sbbg_pkg.sv -----
package sbbg_pkg;

   localparam int NUM_LANES = 4;
   localparam int REM_W     = 7;

   // Generator constants
   localparam logic [31:0] LCG_MUL = 32'd69069;
   localparam logic [63:0] LCG_ADD = 64'd12345;
   localparam logic [31:0] MWC_MUL = 32'd698769069;

   // Reseed constants
   localparam logic [31:0] XS_HASH_MUL  = 32'd2109210;
   localparam logic [31:0] XS_SEED_MUL  = 32'd2121212;
   localparam logic [31:0] MWC_SEED_MUL = 32'd101112;
   localparam logic [31:0] CAR_SEED_MUL = 32'd12121;
   localparam logic [31:0] CAR_TRI_MUL  = 32'd6;
   localparam logic [63:0] XS_SEED_ADD  = 64'd1;
   localparam logic [63:0] CAR_SEED_ADD = 64'd7;
   localparam logic [63:0] MWC_SEED_XOR = 64'd13;

   // Reset values of the state words
   localparam logic [63:0] LCG_INIT   = 64'd123456789;
   localparam logic [63:0] XS_INIT    = 64'd362436000;
   localparam logic [63:0] MWC_INIT   = 64'd521288629;
   localparam logic [63:0] CARRY_INIT = 64'd7654321;

   // Remainder moduli
   localparam logic [REM_W-1:0] MOD_17     = 7'd17;
   localparam logic [REM_W-1:0] MOD_7      = 7'd7;
   localparam logic [REM_W-1:0] MOD_3      = 7'd3;
   localparam logic [REM_W-1:0] MOD_107    = 7'd107;
   localparam logic [REM_W-1:0] MOD_LETTER = 7'd26;
   localparam logic [REM_W-1:0] MOD_CHANCE = 7'd101;

   // Remainder lane assignment
   localparam int LANE_M17    = 0;
   localparam int LANE_M7     = 1;
   localparam int LANE_M3     = 2;
   localparam int LANE_M107   = 3;
   localparam int LANE_LETTER = 0;
   localparam int LANE_CHANCE = 1;

   // Nibble steps for a 64-bit and a 32-bit remainder
   localparam logic [4:0] SEED_MOD_STEPS = 5'd16;
   localparam logic [4:0] BYTE_MOD_STEPS = 5'd8;

   localparam logic [7:0] CHAR_A       = 8'd97;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        hi;
      logic        first;
      logic [63:0] base;
   } mac_op_type;

   typedef struct packed {
      logic load;
      logic run;
   } mod_ctl_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PRE  = 7'b0000010,
      ST_SMOD = 7'b0000100,
      ST_SEED = 7'b0001000,
      ST_DRAW = 7'b0010000,
      ST_BMOD = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_TMP,
      DST_LCG,
      DST_XS,
      DST_MWC,
      DST_MWC_T,
      DST_CARRY
   } dst_type;

endpackage

// ----- src/seeded_block_byte_generator_top.sv -----
// Byte generator built on a KISS-style mix of a 64-bit LCG, a 64-bit xorshift and a 64-bit
// multiply-with-carry. Each accepted transaction yields one byte. All 64-bit products run on
// one shared 32x32 multiply-accumulate unit, one partial product per cycle, and the remainders
// (mod 17, 7, 3, 107 when seeding; mod 26 and 101 per byte) come from a remainder unit that
// folds in four bits per cycle. Between one accept and the next, a byte without reseed runs
// the three draws (MAC partial products, then a combine step, for each), the remainders, the
// load of the result register and the accept. A transaction with block_start set first runs
// the hash product, the seed remainders and the MAC products for the four seed words. The
// input is stalled while a transaction is in progress; a finished byte waits in the result
// register, and the next transaction may start while it waits. The load of the result register
// holds for as long as the previous byte is stalled.
module seeded_block_byte_generator_top import sbbg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_block_start,
   input  logic [63:0] req_block_seed,
   input  logic        req_block_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last_of_block,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   state_type   state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [1:0]  draw_ff, draw_in;
   logic [63:0] seed_ff, seed_in;
   logic        end_ff, end_in;
   logic [63:0] lcg_ff, lcg_in;
   logic [63:0] xs_ff, xs_in;
   logic [63:0] mwc_ff, mwc_in;
   logic [63:0] carry_ff, carry_in;
   logic [63:0] tmp_ff, tmp_in;
   logic [31:0] u_ff, u_in;
   logic [31:0] c_ff, c_in;
   logic [6:0]  level_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   mac_op_type  op;
   logic        mac_en;
   logic [63:0] mac_sum;
   dst_type     dst;

   mod_ctl_type                     mod_ctl;
   logic [NUM_LANES-1:0][63:0]      mod_opnd;
   logic [NUM_LANES-1:0][REM_W-1:0] mod_m;
   logic [NUM_LANES-1:0][REM_W-1:0] mod_rem;

   logic [63:0] x_shl13;
   logic [63:0] x_shl6;
   logic [63:0] x_xor;
   logic [31:0] r17_w;
   logic [31:0] r7_w;
   logic [31:0] k6_w;
   logic [31:0] draw_val;
   logic [31:0] abs_u;
   logic [6:0]  thr;
   logic [7:0]  letter;

   function automatic mac_op_type mk_op(logic [31:0] a, logic [31:0] b, logic hi,
                                        logic first, logic [63:0] base);
      mac_op_type o;
      o.a     = a;
      o.b     = b;
      o.hi    = hi;
      o.first = first;
      o.base  = base;
      return o;
   endfunction

   function automatic logic [63:0] xorshift(logic [63:0] v);
      logic [63:0] t;
      t = v ^ (v << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

   // Piecewise interpolation over the bucket table {30,40,...,98,100}
   function automatic logic [6:0] threshold(logic [6:0] lv);
      logic [6:0] t;
      logic [6:0] m;
      m = 7'd0;
      if (lv == 7'd0) begin
         t = 7'd0;
      end else if (lv < 7'd50) begin
         t = lv + 7'd30;
      end else if (lv < 7'd60) begin
         t = 7'd80 + ((lv - 7'd50) >> 1);
      end else if (lv < 7'd70) begin
         t = 7'd85 + ((lv - 7'd60) >> 1);
      end else if (lv < 7'd80) begin
         t = 7'd90 + ((lv - 7'd70) >> 1);
      end else if (lv < 7'd90) begin
         m = lv - 7'd80;
         t = 7'd95 + 7'(m >= 7'd4) + 7'(m >= 7'd7);
      end else if (lv < 7'd100) begin
         t = (lv >= 7'd95) ? 7'd99 : 7'd98;
      end else begin
         t = 7'd100;
      end
      return t;
   endfunction

   sbbg_mac u_mac (
      .clock (clock),
      .en    (mac_en),
      .op    (op),
      .sum   (mac_sum)
   );

   sbbg_mod u_mod (
      .clock   (clock),
      .ctl     (mod_ctl),
      .opnd    (mod_opnd),
      .modulus (mod_m),
      .rem     (mod_rem)
   );

   assign x_shl13  = seed_ff << 13;
   assign x_shl6   = seed_ff << 6;
   assign x_xor    = seed_ff ^ MWC_SEED_XOR;
   assign r17_w    = 32'(mod_rem[LANE_M17]);
   assign r7_w     = 32'(mod_rem[LANE_M7]);
   assign k6_w     = 32'(mod_rem[LANE_M3]) * CAR_TRI_MUL;
   assign draw_val = lcg_ff[31:0] + xs_ff[31:0] + mwc_ff[31:0];
   assign abs_u    = u_ff[31] ? (32'd0 - u_ff) : u_ff;
   assign thr      = threshold(level_ff);
   assign letter   = u_ff[31] ? (CHAR_A - 8'(mod_rem[LANE_LETTER]))
                              : (CHAR_A + 8'(mod_rem[LANE_LETTER]));

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      draw_in      = draw_ff;
      seed_in      = seed_ff;
      end_in       = end_ff;
      lcg_in       = lcg_ff;
      xs_in        = xs_ff;
      mwc_in       = mwc_ff;
      carry_in     = carry_ff;
      tmp_in       = tmp_ff;
      u_in         = u_ff;
      c_in         = c_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      op           = '0;
      mac_en       = 1'b0;
      dst          = DST_NONE;
      mod_ctl      = '0;
      mod_opnd     = '0;
      mod_m        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               seed_in  = req_block_seed;
               end_in   = req_block_end;
               step_in  = 5'd0;
               draw_in  = 2'd0;
               state_in = req_block_start ? ST_PRE : ST_DRAW;
            end
         end

         ST_PRE: begin
            mac_en = 1'b1;
            if (step_ff == 5'd0) begin
               op      = mk_op(seed_ff[31:0], XS_HASH_MUL, 1'b0, 1'b1, 64'd0);
               step_in = 5'd1;
            end else begin
               op       = mk_op(seed_ff[63:32], XS_HASH_MUL, 1'b1, 1'b0, 64'd0);
               dst      = DST_TMP;
               step_in  = 5'd0;
               state_in = ST_SMOD;
            end
         end

         ST_SMOD: begin
            mod_opnd[LANE_M17]  = seed_ff;
            mod_opnd[LANE_M7]   = seed_ff;
            mod_opnd[LANE_M3]   = seed_ff;
            mod_opnd[LANE_M107] = tmp_ff;
            mod_m[LANE_M17]     = MOD_17;
            mod_m[LANE_M7]      = MOD_7;
            mod_m[LANE_M3]      = MOD_3;
            mod_m[LANE_M107]    = MOD_107;
            mod_ctl.load        = (step_ff == 5'd0);
            mod_ctl.run         = (step_ff != 5'd0);
            if (step_ff == SEED_MOD_STEPS) begin
               step_in  = 5'd0;
               state_in = ST_SEED;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end

         ST_SEED: begin
            mac_en  = 1'b1;
            step_in = step_ff + 5'd1;
            case (step_ff)
               // lcg = x*69069 + 12345 + x*x + (x%17)*(x<<13)
               5'd0:  op = mk_op(seed_ff[31:0], LCG_MUL, 1'b0, 1'b1, LCG_ADD);
               5'd1:  op = mk_op(seed_ff[63:32], LCG_MUL, 1'b1, 1'b0, 64'd0);
               5'd2:  op = mk_op(seed_ff[31:0], seed_ff[31:0], 1'b0, 1'b0, 64'd0);
               5'd3:  op = mk_op(seed_ff[31:0], seed_ff[63:32], 1'b1, 1'b0, 64'd0);
               5'd4:  op = mk_op(seed_ff[63:32], seed_ff[31:0], 1'b1, 1'b0, 64'd0);
               5'd5:  op = mk_op(x_shl13[31:0], r17_w, 1'b0, 1'b0, 64'd0);
               5'd6: begin
                  op  = mk_op(x_shl13[63:32], r17_w, 1'b1, 1'b0, 64'd0);
                  dst = DST_LCG;
               end
               // xs = (x*2109210)%107 + 1 + 2121212*x
               5'd7:  op = mk_op(seed_ff[31:0], XS_SEED_MUL, 1'b0, 1'b1,
                                 XS_SEED_ADD + 64'(mod_rem[LANE_M107]));
               5'd8: begin
                  op  = mk_op(seed_ff[63:32], XS_SEED_MUL, 1'b1, 1'b0, 64'd0);
                  dst = DST_XS;
               end
               // tmp = x*x, then tmp = tmp*x
               5'd9:  op = mk_op(seed_ff[31:0], seed_ff[31:0], 1'b0, 1'b1, 64'd0);
               5'd10: op = mk_op(seed_ff[31:0], seed_ff[63:32], 1'b1, 1'b0, 64'd0);
               5'd11: begin
                  op  = mk_op(seed_ff[63:32], seed_ff[31:0], 1'b1, 1'b0, 64'd0);
                  dst = DST_TMP;
               end
               5'd12: op = mk_op(tmp_ff[31:0], seed_ff[31:0], 1'b0, 1'b1, 64'd0);
               5'd13: op = mk_op(tmp_ff[31:0], seed_ff[63:32], 1'b1, 1'b0, 64'd0);
               5'd14: begin
                  op  = mk_op(tmp_ff[63:32], seed_ff[31:0], 1'b1, 1'b0, 64'd0);
                  dst = DST_TMP;
               end
               // mwc = (x^3 >> 3) + 101112*(x^13) + (x%7)*(x<<6)
               5'd15: op = mk_op(x_xor[31:0], MWC_SEED_MUL, 1'b0, 1'b1, tmp_ff >> 3);
               5'd16: op = mk_op(x_xor[63:32], MWC_SEED_MUL, 1'b1, 1'b0, 64'd0);
               5'd17: op = mk_op(x_shl6[31:0], r7_w, 1'b0, 1'b0, 64'd0);
               5'd18: begin
                  op  = mk_op(x_shl6[63:32], r7_w, 1'b1, 1'b0, 64'd0);
                  dst = DST_MWC;
               end
               // carry = 7 + x*(6*(x%3)) + 12121*x
               5'd19: op = mk_op(seed_ff[31:0], k6_w, 1'b0, 1'b1, CAR_SEED_ADD);
               5'd20: op = mk_op(seed_ff[63:32], k6_w, 1'b1, 1'b0, 64'd0);
               5'd21: op = mk_op(seed_ff[31:0], CAR_SEED_MUL, 1'b0, 1'b0, 64'd0);
               5'd22: begin
                  op       = mk_op(seed_ff[63:32], CAR_SEED_MUL, 1'b1, 1'b0, 64'd0);
                  dst      = DST_CARRY;
                  step_in  = 5'd0;
                  draw_in  = 2'd0;
                  state_in = ST_DRAW;
               end
               default: begin
                  mac_en   = 1'b0;
                  step_in  = 5'd0;
                  state_in = ST_DRAW;
               end
            endcase
         end

         ST_DRAW: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               5'd0: begin
                  mac_en = 1'b1;
                  op     = mk_op(lcg_ff[31:0], LCG_MUL, 1'b0, 1'b1, LCG_ADD);
               end
               5'd1: begin
                  mac_en = 1'b1;
                  op     = mk_op(lcg_ff[63:32], LCG_MUL, 1'b1, 1'b0, 64'd0);
                  dst    = DST_LCG;
                  xs_in  = xorshift(xs_ff);
               end
               5'd2: begin
                  mac_en = 1'b1;
                  op     = mk_op(mwc_ff[31:0], MWC_MUL, 1'b0, 1'b1, carry_ff);
               end
               5'd3: begin
                  mac_en = 1'b1;
                  op     = mk_op(mwc_ff[63:32], MWC_MUL, 1'b1, 1'b0, 64'd0);
                  dst    = DST_MWC_T;
               end
               default: begin
                  // combine the three words into one draw
                  step_in = 5'd0;
                  if (draw_ff == 2'd0) begin
                     u_in = draw_val;
                  end else if (draw_ff == 2'd1) begin
                     u_in = u_ff + draw_val;
                  end else begin
                     c_in = draw_val;
                  end
                  if (draw_ff == 2'd2) begin
                     state_in = ST_BMOD;
                  end else begin
                     draw_in = draw_ff + 2'd1;
                  end
               end
            endcase
         end

         ST_BMOD: begin
            mod_opnd[LANE_LETTER] = {abs_u, 32'd0};
            mod_opnd[LANE_CHANCE] = {c_ff, 32'd0};
            mod_m[LANE_LETTER]    = MOD_LETTER;
            mod_m[LANE_CHANCE]    = MOD_CHANCE;
            mod_m[LANE_M3]        = MOD_LETTER;
            mod_m[LANE_M107]      = MOD_CHANCE;
            mod_ctl.load          = (step_ff == 5'd0);
            mod_ctl.run           = (step_ff != 5'd0);
            if (step_ff == BYTE_MOD_STEPS) begin
               step_in  = 5'd0;
               state_in = ST_OUT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end

         ST_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = end_ff;
               if (end_ff) begin
                  rsp_byte_in = CHAR_NEWLINE;
               end else if (mod_rem[LANE_CHANCE] <= thr) begin
                  rsp_byte_in = CHAR_ZERO;
               end else begin
                  rsp_byte_in = letter;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      case (dst)
         DST_TMP:   tmp_in   = mac_sum;
         DST_LCG:   lcg_in   = mac_sum;
         DST_XS:    xs_in    = mac_sum;
         DST_MWC:   mwc_in   = mac_sum;
         DST_MWC_T: begin
            mwc_in   = mac_sum;
            carry_in = {32'd0, mac_sum[63:32]};
         end
         DST_CARRY: carry_in = mac_sum;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         level_ff     <= 7'd0;
         lcg_ff       <= LCG_INIT;
         xs_ff        <= XS_INIT;
         mwc_ff       <= MWC_INIT;
         carry_ff     <= CARRY_INIT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lcg_ff       <= lcg_in;
         xs_ff        <= xs_in;
         mwc_ff       <= mwc_in;
         carry_ff     <= carry_in;
         if (csr_wr_en) begin
            level_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      draw_ff     <= draw_in;
      seed_ff     <= seed_in;
      end_ff      <= end_in;
      tmp_ff      <= tmp_in;
      u_ff        <= u_in;
      c_ff        <= c_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = rsp_byte_ff;
   assign rsp_last_of_block = rsp_last_ff;

endmodule

// ----- src/sbbg_mac.sv -----
module sbbg_mac import sbbg_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  mac_op_type  op,
   output logic [63:0] sum
);

   logic [63:0] acc_ff;
   logic [63:0] acc_in;
   logic [63:0] prod;
   logic [63:0] prod_sh;

   always_comb begin
      prod    = {32'd0, op.a} * {32'd0, op.b};
      prod_sh = op.hi ? {prod[31:0], 32'd0} : prod;
      acc_in  = (op.first ? op.base : acc_ff) + prod_sh;
   end

   assign sum = acc_in;

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ----- src/sbbg_mod.sv -----
module sbbg_mod import sbbg_pkg::*; (
   input  logic                                clock,
   input  mod_ctl_type                         ctl,
   input  logic [NUM_LANES-1:0][63:0]          opnd,
   input  logic [NUM_LANES-1:0][REM_W-1:0]     modulus,
   output logic [NUM_LANES-1:0][REM_W-1:0]     rem
);

   logic [NUM_LANES-1:0][63:0]      opnd_ff;
   logic [NUM_LANES-1:0][REM_W-1:0] mod_ff;
   logic [NUM_LANES-1:0][REM_W-1:0] rem_ff;
   logic [NUM_LANES-1:0][REM_W-1:0] rem_in;

   // Fold in one nibble: (rem * 16 + nibble) stays below 16 * m
   function automatic logic [REM_W-1:0] reduce(logic [REM_W+3:0] v_in, logic [REM_W-1:0] m);
      logic [REM_W+3:0] v;
      logic [REM_W+3:0] mk;
      v = v_in;
      for (int k = 3; k >= 0; k--) begin
         mk = (REM_W+4)'(m) << k;
         if (v >= mk) begin
            v = v - mk;
         end
      end
      return v[REM_W-1:0];
   endfunction

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         rem_in[i] = reduce({rem_ff[i], opnd_ff[i][63:60]}, mod_ff[i]);
      end
   end

   assign rem = rem_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         opnd_ff <= opnd;
         mod_ff  <= modulus;
         rem_ff  <= '0;
      end else if (ctl.run) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            opnd_ff[i] <= {opnd_ff[i][59:0], 4'd0};
         end
         rem_ff <= rem_in;
      end
   end

endmodule
